FILE: hdl/rfp_pkg.sv
// rfp_pkg: shared constants, types and the hex decode for the RFID frame parser.
// Used by rfp_frame_asm, rfp_tag_check and rfid_ascii_frame_parser.
package rfp_pkg;

	localparam int unsigned FRAME_LEN = 14;
	localparam int unsigned BODY_LEN  = 12;
	localparam int unsigned POS_W     = 4;

	localparam logic [7:0]  START_BYTE    = 8'h02;
	localparam logic [7:0]  END_BYTE      = 8'h03;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

	localparam logic [POS_W-1:0] POS_FIRST = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

	typedef logic [7:0] char_t;
	typedef char_t [BODY_LEN-1:0] body_t;

	// frame completion status, one cycle wide
	typedef struct packed {
		logic done;
		logic end_ok;
	} frame_evt_t;

	// Decode one uppercase hex character; anything else reads as zero.
	function automatic logic [3:0] hex_nibble(input char_t ch);
		logic [3:0] nib;
		nib = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			nib = 4'(ch - 8'h30);
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			nib = 4'(ch - 8'h37);
		end
		return nib;
	endfunction

endpackage

FILE: hdl/rfp_frame_asm.sv
// rfp_frame_asm: frame position counter and 14-byte frame store.
// Depends on rfp_pkg.
module rfp_frame_asm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_en,
	input  rfp_pkg::char_t      rx_byte,
	output rfp_pkg::frame_evt_t evt,
	output rfp_pkg::body_t      body
);

	logic [rfp_pkg::POS_W-1:0] pos_q;
	rfp_pkg::char_t            mem_q [rfp_pkg::FRAME_LEN];
	logic                      take;

	// accept a byte inside a frame, or a start byte outside one
	assign take = byte_en && (pos_q != rfp_pkg::POS_FIRST || rx_byte == rfp_pkg::START_BYTE);

	// flag the closing byte of a frame
	assign evt.done   = take && (pos_q == rfp_pkg::POS_LAST);
	assign evt.end_ok = (rx_byte == rfp_pkg::END_BYTE);

	// advance the position, wrap after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= rfp_pkg::POS_FIRST;
		end else if (take) begin
			if (pos_q == rfp_pkg::POS_LAST) begin
				pos_q <= rfp_pkg::POS_FIRST;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// store the byte at the current position
	always_ff @(posedge clk) begin
		if (take) begin
			mem_q[pos_q] <= rx_byte;
		end
	end

	// present bytes 1 to 12 of the frame
	always_comb begin
		for (int i = 0; i < rfp_pkg::BODY_LEN; i++) begin
			body[i] = mem_q[i + 1];
		end
	end

endmodule

FILE: hdl/rfp_tag_check.sv
// rfp_tag_check: XOR checksum, tag compare, last tag and forget timer.
// Depends on rfp_pkg; fed by rfp_frame_asm.
module rfp_tag_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_en,
	input  rfp_pkg::frame_evt_t evt,
	input  rfp_pkg::body_t      body,
	input  logic [15:0]         timeout,
	output logic                res_valid,
	output logic [63:0]         res_tag
);

	logic [63:0] last_tag_q;
	logic [15:0] elapsed_q;
	logic [15:0] elapsed_inc;
	logic [7:0]  sum;
	logic [63:0] tag;
	logic        frame_ok;

	// fold the six hex pairs and gather the eight tag characters
	always_comb begin
		sum = 8'd0;
		for (int k = 0; k < rfp_pkg::BODY_LEN / 2; k++) begin
			sum = sum ^ {rfp_pkg::hex_nibble(body[2*k]), rfp_pkg::hex_nibble(body[2*k+1])};
		end
		tag = 64'd0;
		for (int k = 2; k < 10; k++) begin
			tag = {tag[55:0], body[k]};
		end
	end

	assign frame_ok    = evt.done && evt.end_ok;
	assign res_valid   = frame_ok && (sum == 8'd0) && (tag != last_tag_q);
	assign res_tag     = tag;
	assign elapsed_inc = (elapsed_q == rfp_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	// hold the last tag, count ticks, drop the tag's first character on timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tag_q <= 64'd0;
			elapsed_q  <= 16'd0;
		end else if (tick_en) begin
			elapsed_q <= elapsed_inc;
			if (last_tag_q[63:56] != 8'd0 && elapsed_inc > timeout) begin
				last_tag_q[63:56] <= 8'd0;
			end
		end else if (frame_ok) begin
			elapsed_q <= 16'd0;
			if (res_valid) begin
				last_tag_q <= tag;
			end
		end
	end

endmodule

FILE: hdl/rfid_ascii_frame_parser.sv
// rfid_ascii_frame_parser: top level; input register, config register, result register.
// Depends on rfp_pkg, rfp_frame_asm and rfp_tag_check.
//
//   channel  signals                          width    direction
//   in       in_valid in_ready cmd rx_byte    1 + 8    to block
//   out      out_valid out_ready tag_chars    64       from block
//   cfg      cfg_valid cfg_ready forget_...   16       to block
//
// One item per cycle while no result is stalled: an item sits in the input
// register, where the frame store, checksum and tag compare run, and its
// result lands in the output register.
// Reset clears position, last tag, elapsed count and sets the timeout to 1000.
// A result held in the output register stalls the input register only while
// out_ready is low; cfg_ready is always high.
module rfid_ascii_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] tag_chars,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] forget_timeout_ms
);

	logic                valid_s1;
	logic                cmd_s1;
	logic [7:0]          rx_byte_s1;
	logic                out_valid_q;
	logic [63:0]         tag_chars_q;
	logic [15:0]         timeout_q;
	logic                adv;
	rfp_pkg::frame_evt_t evt;
	rfp_pkg::body_t      body;
	logic                res_valid;
	logic [63:0]         res_tag;

	// process the held item when the result slot is free or being taken
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign tag_chars = tag_chars_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1     <= cmd;
			rx_byte_s1 <= rx_byte;
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rfp_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= forget_timeout_ms;
		end
	end

	rfp_frame_asm u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (adv && !cmd_s1),
		.rx_byte (rx_byte_s1),
		.evt     (evt),
		.body    (body)
	);

	rfp_tag_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_en   (adv && cmd_s1),
		.evt       (evt),
		.body      (body),
		.timeout   (timeout_q),
		.res_valid (res_valid),
		.res_tag   (res_tag)
	);

	// result register: load on advance, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			tag_chars_q <= res_tag;
		end
	end

	// a new result comes only from a byte processed in the previous cycle
	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && !cmd_s1))
		else $error("result without a processed byte");

	// input stalls only behind a held item and a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without cause");

	// a frame closes only while a byte is processed
	a_frame_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		evt.done |-> (adv && !cmd_s1))
		else $error("frame completion without byte");

endmodule
